@@ rtl/fck_pkg.sv @@
// ----------------------------------------------------------------------------
// fck_pkg
// Shared types, constants and the byte fold function for the frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package fck_pkg;

    // check algorithm codes
    typedef enum logic
    {
        MODE_CRC = 1'b0,
        MODE_SUM = 1'b1
    } fck_mode_t;

    // end-of-frame status codes
    typedef enum logic [1:0]
    {
        ST_MATCH    = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_SHORT    = 2'd2,
        ST_LONG     = 2'd3
    } fck_status_t;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] SUM_SEED = 16'h0000;

    // one buffered input transaction
    typedef struct packed
    {
        logic       valid;
        logic       last;
        logic [7:0] data;
    } fck_item_t;

    // fold one byte into the reflected crc-16, lsb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fck_in_stage.sv @@
// ----------------------------------------------------------------------------
// fck_in_stage
// Input register: captures one byte transaction and holds it until the
// check stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fck_in_stage
    import fck_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output fck_item_t       item,
    input  wire logic       take
);

    logic       valid_reg;
    logic       valid_next;
    logic       last_reg;
    logic [7:0] data_reg;

    // stall while a held transaction cannot move on
    assign in_stall = valid_reg & ~take;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
            valid_next = in_valid;
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            last_reg <= last_byte;
            data_reg <= data_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.last  = last_reg;
    assign item.data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/fck_check.sv @@
// ----------------------------------------------------------------------------
// fck_check
// Frame state, running check update and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fck_check
    import fck_pkg::*;
#(
    parameter int MAX_PAYLOAD = 255
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire fck_item_t   item,
    output logic             take,
    input  wire logic        mode_wr,
    input  wire logic        mode_val,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [15:0]      computed_check,
    output logic [15:0]      received_check
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 4);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PAYLOAD + 3);
    localparam logic [CNT_W-1:0] CNT_LONG  = CNT_W'(MAX_PAYLOAD + 2);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

    fck_mode_t        mode_reg;
    fck_mode_t        mode_next;
    logic [15:0]      run_reg;
    logic [15:0]      run_next;
    logic [7:0]       held0_reg;
    logic [7:0]       held0_next;
    logic [7:0]       held1_reg;
    logic [7:0]       held1_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    fck_status_t      status_reg;
    fck_status_t      status_next;
    logic [15:0]      computed_reg;
    logic [15:0]      received_reg;

    logic             out_free;
    logic             emit;
    logic [15:0]      seed;
    logic [15:0]      folded;
    logic [15:0]      run_upd;
    logic [CNT_W-1:0] cnt_upd;
    logic [15:0]      received;

    // transaction moves unless it ends a frame and the result slot is busy
    assign out_free = ~out_valid_reg | ~out_stall;
    assign take     = item.valid & (~item.last | out_free);
    assign emit     = take & item.last;

    // fold the byte leaving the two-byte delay
    always_comb
    begin
        if (mode_reg == MODE_SUM)
            folded = run_reg + {8'h00, held0_reg};
        else
            folded = crc16_byte(run_reg, held0_reg);
    end

    assign run_upd  = (cnt_reg >= CNT_TWO) ? folded : run_reg;
    assign cnt_upd  = (cnt_reg < CNT_LIMIT) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign received = {item.data, held1_reg};

    // end-of-frame status, short first, then long, then compare
    always_comb
    begin
        if (cnt_upd < CNT_TWO)
            status_next = ST_SHORT;
        else if (cnt_upd > CNT_LONG)
            status_next = ST_LONG;
        else if (run_upd == received)
            status_next = ST_MATCH;
        else
            status_next = ST_MISMATCH;
    end

    // frame state next values
    always_comb
    begin
        mode_next  = mode_reg;
        run_next   = run_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        cnt_next   = cnt_reg;
        seed       = (mode_reg == MODE_SUM) ? SUM_SEED : CRC_SEED;
        if (mode_wr)
        begin
            mode_next  = fck_mode_t'(mode_val);
            run_next   = mode_val ? SUM_SEED : CRC_SEED;
            held0_next = 8'h00;
            held1_next = 8'h00;
            cnt_next   = '0;
        end
        else if (emit)
        begin
            run_next   = seed;
            held0_next = 8'h00;
            held1_next = 8'h00;
            cnt_next   = '0;
        end
        else if (take)
        begin
            run_next   = run_upd;
            held0_next = held1_reg;
            held1_next = item.data;
            cnt_next   = cnt_upd;
        end
    end

    // result slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    // control and frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_CRC;
            run_reg       <= CRC_SEED;
            held0_reg     <= 8'h00;
            held1_reg     <= 8'h00;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            run_reg       <= run_next;
            held0_reg     <= held0_next;
            held1_reg     <= held1_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg   <= status_next;
            computed_reg <= run_upd;
            received_reg <= received;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign computed_check = computed_reg;
    assign received_check = received_reg;

endmodule

`default_nettype wire

@@ rtl/frame_check_crc16_or_sum.sv @@
// an input transaction passes the input register and then the result register
// one byte per cycle unless stalled; crc byte fold unrolled between the two registers
// a frame result waiting on a stalled output holds back only the next frame-ending byte
// reset: asynchronous active low; crc mode, seed 0xFFFF, delay and count cleared
// a mode write restarts the frame in progress
// ----------------------------------------------------------------------------
// frame_check_crc16_or_sum
// Checks a byte-serial frame against its little-endian crc-16 or sum trailer.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_check_crc16_or_sum
    import fck_pkg::*;
#(
    parameter int MAX_PAYLOAD = 255
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        check_mode,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [15:0]      computed_check,
    output logic [15:0]      received_check
);

    fck_item_t item;
    logic      take;

    // configuration is to be written only while idle; the block itself does not enforce this
    assign cfg_ready = 1'b1;

    // input register
    fck_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .item      (item),
        .take      (take)
    );

    // check update and result register
    fck_check #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .take           (take),
        .mode_wr        (cfg_valid & cfg_ready),
        .mode_val       (check_mode),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .computed_check (computed_check),
        .received_check (received_check)
    );

endmodule

`default_nettype wire
